### rtl/core/vt4_pkg.sv
// ----------------------------------------------------------------------------
// vt4_pkg
// Shared types and constants of the 4x4 vertex transform block.
// ----------------------------------------------------------------------------
package vt4_pkg;

  // Matrix shape and coefficient layout (row*4+column).
  localparam int MAT_DIM  = 4;
  localparam int MAT_SIZE = MAT_DIM * MAT_DIM;
  localparam int PT_DIM   = 3;
  localparam int IDX_W    = 4;

  // Data widths: 32-bit coefficients and coordinates, full products and
  // a sum of three products with room for the carries.
  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + 2;

  // Request codes carried in req_type.
  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_XFORM = 1'b1
  } req_t;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

### rtl/core/vt4_in_if.sv
// ----------------------------------------------------------------------------
// vt4_in_if
// Request channel: coefficient loads and points to transform.
// ----------------------------------------------------------------------------
interface vt4_in_if;
  logic                valid;
  logic                ready;
  vt4_pkg::req_t       req_type;
  logic [3:0]          coef_index;
  logic signed [31:0]  coef_value;
  logic signed [31:0]  point_x;
  logic signed [31:0]  point_y;
  logic signed [31:0]  point_z;
  logic                last_in;

  modport source (
    output valid, req_type, coef_index, coef_value, point_x, point_y, point_z, last_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, coef_index, coef_value, point_x, point_y, point_z, last_in,
    output ready
  );
endinterface

### rtl/core/vt4_out_if.sv
// ----------------------------------------------------------------------------
// vt4_out_if
// Result channel: one transformed point per word.
// ----------------------------------------------------------------------------
interface vt4_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  out_x;
  logic signed [31:0]  out_y;
  logic signed [31:0]  out_z;
  logic signed [31:0]  out_w;
  logic                last_out;

  modport source (
    output valid, out_x, out_y, out_z, out_w, last_out,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w, last_out,
    output ready
  );
endinterface

### rtl/core/vertex_transform_4x4_top.sv
// A point accepted on the request channel passes the product registers, the
// column-sum registers and then the output register (multiply, sum, shift and
// saturate) before it appears on the result channel.
// Throughput: one word per cycle on either channel; the three stages advance
// together whenever the output register is empty or being taken.
// Reset: synchronous, active low; clears all stage valid bits and the matrix.
// ----------------------------------------------------------------------------
// vertex_transform_4x4_top
// Streams 3D points through a stored 4x4 matrix (row-vector convention) in
// signed fixed point with FRAC_BITS fraction bits, saturating each result.
// ----------------------------------------------------------------------------
module vertex_transform_4x4_top #(
  parameter int FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  vt4_in_if.sink    in_bus,
  vt4_out_if.source out_bus
);
  import vt4_pkg::*;

  // The coefficient store is sixteen registers. Each multiplier reads its
  // own fixed entry, so no read port is shared. A load word writes the
  // store at the edge where it is accepted; a point accepted at any later
  // edge sees the new matrix, which is exactly the word order.
  data_t mat_r [MAT_SIZE];

  // The whole pipeline moves as one when the output register can take a
  // new word. A word that is stalled keeps all stages frozen, so nothing is
  // lost or repeated.
  logic adv;
  logic in_acc;
  logic in_xform;

  assign adv          = !out_bus.valid || out_bus.ready;
  assign in_bus.ready = adv;
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign in_xform     = in_acc && (in_bus.req_type == REQ_XFORM);

  // Stage 1: the twelve 32x32 products straight from the input port and the
  // store, plus the translation row which needs no multiply.
  data_t                    pt [PT_DIM];
  logic signed [PROD_W-1:0] prod_nxt [MAT_DIM][PT_DIM];
  logic signed [PROD_W-1:0] prod_r   [MAT_DIM][PT_DIM];
  data_t                    s1_trans_r [MAT_DIM];
  logic                     s1_vld_r;
  logic                     s1_last_r;

  assign pt[0] = in_bus.point_x;
  assign pt[1] = in_bus.point_y;
  assign pt[2] = in_bus.point_z;

  always_comb begin
    for (int c = 0; c < MAT_DIM; c++) begin
      for (int r = 0; r < PT_DIM; r++) begin
        prod_nxt[c][r] = pt[r] * mat_r[IDX_W'(r * MAT_DIM + c)];
      end
    end
  end

  // Stage 2: the three products of each column summed at full precision.
  logic signed [SUM_W-1:0] sum_nxt [MAT_DIM];
  logic signed [SUM_W-1:0] s2_sum_r [MAT_DIM];
  data_t                   s2_trans_r [MAT_DIM];
  logic                    s2_vld_r;
  logic                    s2_last_r;

  always_comb begin
    for (int c = 0; c < MAT_DIM; c++) begin
      sum_nxt[c] = SUM_W'(prod_r[c][0]) + SUM_W'(prod_r[c][1]) + SUM_W'(prod_r[c][2]);
    end
  end

  // Stage 3: the arithmetic right shift floors toward minus infinity, the
  // translation term is already aligned and is added afterwards, and the
  // result clamps to the signed 32-bit range. This is the output register.
  logic signed [SUM_W-1:0] shf  [MAT_DIM];
  data_t                   res_nxt [MAT_DIM];
  data_t                   res_r   [MAT_DIM];
  logic                    out_vld_r;
  logic                    out_last_r;

  always_comb begin
    for (int c = 0; c < MAT_DIM; c++) begin
      shf[c] = (s2_sum_r[c] >>> FRAC_BITS) + SUM_W'(s2_trans_r[c]);
      if ((&shf[c][SUM_W-1:DATA_W-1]) || !(|shf[c][SUM_W-1:DATA_W-1])) begin
        res_nxt[c] = shf[c][DATA_W-1:0];
      end else if (shf[c][SUM_W-1]) begin
        res_nxt[c] = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        res_nxt[c] = {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
  end

  // Control state: valid bits and the coefficient store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < MAT_SIZE; i++) begin
        mat_r[i] <= '0;
      end
    end else begin
      if (adv) begin
        s1_vld_r  <= in_xform;
        s2_vld_r  <= s1_vld_r;
        out_vld_r <= s2_vld_r;
      end
      if (in_acc && (in_bus.req_type == REQ_LOAD)) begin
        mat_r[in_bus.coef_index] <= in_bus.coef_value;
      end
    end
  end

  // Payload registers move with the pipeline and need no reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r     <= prod_nxt;
      s1_last_r  <= in_bus.last_in;
      s2_sum_r   <= sum_nxt;
      s2_last_r  <= s1_last_r;
      s2_trans_r <= s1_trans_r;
      res_r      <= res_nxt;
      out_last_r <= s2_last_r;
      for (int c = 0; c < MAT_DIM; c++) begin
        s1_trans_r[c] <= mat_r[IDX_W'(PT_DIM * MAT_DIM + c)];
      end
    end
  end

  assign out_bus.valid    = out_vld_r;
  assign out_bus.out_x    = res_r[0];
  assign out_bus.out_y    = res_r[1];
  assign out_bus.out_z    = res_r[2];
  assign out_bus.out_w    = res_r[3];
  assign out_bus.last_out = out_last_r;

  // A first-stage word exists only for a point taken in, or one held by a stall.
  a_s1_source : assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> $past(in_xform) || $past(!adv))
    else $error("stage one valid without an accepted point");

  // A stall freezes the inner stages.
  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.ready) |=> $stable(s1_vld_r) && $stable(s2_vld_r))
    else $error("pipeline moved during a stall");

  // A load word lands in the addressed coefficient.
  a_load_write : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_bus.req_type == REQ_LOAD))
      |=> mat_r[$past(in_bus.coef_index)] == $past(in_bus.coef_value))
    else $error("coefficient load not stored");

  // Reset empties the output register.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_bus.valid)
    else $error("result valid right after reset");

endmodule

### tb/sv/tb_vertex_transform_4x4_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_transform_4x4_top
// Self-checking bench for the 4x4 vertex transform. Coefficient loads and
// points are pushed through the request channel with random gaps. A local
// copy of the matrix predicts each transformed point exactly, with floor
// rounding and saturation. The prediction is checked field by field against
// the result channel while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_vertex_transform_4x4_top;
  import vt4_pkg::*;

  localparam int FRAC_BITS = 16;

  // Run length and back-pressure tuning.
  localparam int RANDOM_WORDS   = 1200;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int LONG_HOLD_AT   = 400;   // result count that starts the long stall
  localparam int LONG_HOLD_LEN  = 150;   // cycles the receiver holds off then
  localparam int SETTLE_CYCLES  = 12;    // a few times the three-stage latency
  localparam int PRINT_CAP      = 60;    // mismatch lines printed before going quiet

  // The exact sum of three 64-bit products plus the shifted translation term
  // fits in 68 signed bits, so the whole column is computed without loss.
  typedef logic signed [SUM_W+1:0] col_acc_t;

  // One request word as the sender offers it, plus the sender's pacing.
  typedef struct {
    req_t             kind;
    logic [IDX_W-1:0] idx;
    data_t            coef;
    data_t            px;
    data_t            py;
    data_t            pz;
    logic             last;
    int unsigned      gap;          // idle cycles before this word is offered
    bit               wait_drain;   // hold this word until every result is back
  } req_word_t;

  // One transformed point as the result channel carries it.
  typedef struct {
    data_t x;
    data_t y;
    data_t z;
    data_t w;
    logic  last;
  } xform_point_t;

  logic clk;
  logic rst_n;

  vt4_in_if  in_bus();
  vt4_out_if out_bus();

  vertex_transform_4x4_top #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  // Mirror of the coefficient store, updated on every accepted load word.
  data_t        coef_mirror [MAT_SIZE];
  // Words waiting to be offered, and points whose results are still due.
  req_word_t    pending_words_q [$];
  xform_point_t due_points_q [$];

  int unsigned  mismatch_count;
  int unsigned  results_seen;
  int unsigned  cycle_count;

  // Handshake flags, sampled at the rising edge and used by the drivers at the
  // following falling edge.
  bit           in_fire;
  bit           out_fire;

  // Sender and receiver pacing state.
  bit           word_on_bus;
  int unsigned  send_gap_left;
  int unsigned  recv_hold_left;

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // One output column: x*M0c + y*M1c + z*M2c + (M3c << FRAC_BITS), floored by
  // an arithmetic shift and clamped to the signed 32-bit range.
  function automatic data_t transform_column(data_t px, data_t py, data_t pz, int col);
    col_acc_t ax, ay, az;
    col_acc_t m0, m1, m2, m3;
    col_acc_t acc;
    ax  = px;
    ay  = py;
    az  = pz;
    m0  = coef_mirror[col];
    m1  = coef_mirror[MAT_DIM + col];
    m2  = coef_mirror[2 * MAT_DIM + col];
    m3  = coef_mirror[3 * MAT_DIM + col];
    acc = ax * m0 + ay * m1 + az * m2 + (m3 <<< FRAC_BITS);
    acc = acc >>> FRAC_BITS;
    if (acc > 68'sd2147483647) return 32'sh7FFF_FFFF;
    if (acc < -68'sd2147483648) return 32'sh8000_0000;
    return data_t'(acc[DATA_W-1:0]);
  endfunction

  // Apply one accepted request word to the mirror and queue its result.
  task automatic absorb_request();
    xform_point_t pt;
    if (in_bus.req_type == REQ_LOAD) begin
      coef_mirror[in_bus.coef_index] = in_bus.coef_value;
    end else begin
      pt.x    = transform_column(in_bus.point_x, in_bus.point_y, in_bus.point_z, 0);
      pt.y    = transform_column(in_bus.point_x, in_bus.point_y, in_bus.point_z, 1);
      pt.z    = transform_column(in_bus.point_x, in_bus.point_y, in_bus.point_z, 2);
      pt.w    = transform_column(in_bus.point_x, in_bus.point_y, in_bus.point_z, 3);
      pt.last = in_bus.last_in;
      due_points_q.push_back(pt);
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, data_t got, data_t want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("[%0t] %s: got %h, want %h (result %0d)", $realtime, what, got, want,
               results_seen);
    end
  endtask

  // Compare the word on the result channel with the oldest due point.
  task automatic check_result();
    xform_point_t want;
    if (due_points_q.size() == 0) begin
      report_mismatch("unexpected word", out_bus.out_x, 'x);
    end else begin
      want = due_points_q.pop_front();
      if (out_bus.out_x !== want.x) report_mismatch("out_x", out_bus.out_x, want.x);
      if (out_bus.out_y !== want.y) report_mismatch("out_y", out_bus.out_y, want.y);
      if (out_bus.out_z !== want.z) report_mismatch("out_z", out_bus.out_z, want.z);
      if (out_bus.out_w !== want.w) report_mismatch("out_w", out_bus.out_w, want.w);
      if (out_bus.last_out !== want.last) begin
        report_mismatch("last_out", data_t'(out_bus.last_out), data_t'(want.last));
      end
    end
    results_seen++;
  endtask

  // Everything is sampled at the rising edge, before the block's registers
  // take their new values. Results are checked first; a point accepted at
  // this edge must pass the product, sum and output registers to get out.
  always @(posedge clk) begin
    in_fire  = rst_n && in_bus.valid && in_bus.ready;
    out_fire = rst_n && out_bus.valid && out_bus.ready;
    if (out_fire) check_result();
    if (in_fire) absorb_request();
  end

  // --------------------------------------------------------------------------
  // Driver: offers the head of the pending queue at the falling edge. A word
  // leaves the queue once it was taken at the previous rising edge. The valid
  // line is computed first and written once, so a word that follows another
  // with no gap keeps valid high without a glitch.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    req_word_t w;
    if (rst_n) begin
      if (word_on_bus && in_fire) begin
        void'(pending_words_q.pop_front());
        word_on_bus   = 1'b0;
        send_gap_left = (pending_words_q.size() != 0) ? pending_words_q[0].gap : 0;
      end
      if (!word_on_bus && pending_words_q.size() != 0) begin
        if (send_gap_left > 0) begin
          send_gap_left--;
        end else if (!pending_words_q[0].wait_drain || due_points_q.size() == 0) begin
          // A drain word waits here until the block has handed back every
          // result that is due, so the pipeline runs fully empty once.
          w = pending_words_q[0];
          in_bus.req_type   <= w.kind;
          in_bus.coef_index <= w.idx;
          in_bus.coef_value <= w.coef;
          in_bus.point_x    <= w.px;
          in_bus.point_y    <= w.py;
          in_bus.point_z    <= w.pz;
          in_bus.last_in    <= w.last;
          word_on_bus = 1'b1;
        end
      end
      in_bus.valid <= word_on_bus;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: after each word it takes, it draws a random hold-off.
  // Every third stretch of 128 results it takes words back to back.
  // Once, it holds off for a long stretch so that the pipeline fills and the
  // block has to stall its input while the sender keeps offering.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    bit rdy;
    if (rst_n) begin
      if (out_fire) begin
        if (results_seen == LONG_HOLD_AT) begin
          recv_hold_left = LONG_HOLD_LEN;
        end else if (((results_seen / 128) % 3) == 2) begin
          recv_hold_left = 0;
        end else begin
          recv_hold_left = $urandom_range(0, 10);
        end
      end
      if (recv_hold_left > 0) begin
        rdy = 1'b0;
        recv_hold_left--;
      end else begin
        rdy = 1'b1;
      end
      out_bus.ready <= rdy;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // A fixed-point value: mostly full-range random or modest magnitudes within
  // about +/-8.0, with the range limits and a few landmarks mixed in.
  function automatic data_t pick_fixed();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return data_t'($urandom);
    if (sel < 9) return data_t'($urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0000_0000;
      3: return 32'shFFFF_FFFF;
      4: return 32'sh0001_0000;
      default: return 32'shFFFF_0000;
    endcase
  endfunction

  task automatic queue_word(req_t kind, logic [IDX_W-1:0] idx, data_t coef,
                            data_t px, data_t py, data_t pz, logic last,
                            int unsigned gap, bit wait_drain);
    req_word_t w;
    w.kind       = kind;
    w.idx        = idx;
    w.coef       = coef;
    w.px         = px;
    w.py         = py;
    w.pz         = pz;
    w.last       = last;
    w.gap        = gap;
    w.wait_drain = wait_drain;
    pending_words_q.push_back(w);
  endtask

  task automatic queue_load(logic [IDX_W-1:0] idx, data_t coef);
    queue_word(REQ_LOAD, idx, coef, pick_fixed(), pick_fixed(), pick_fixed(),
               1'($urandom_range(0, 1)), 0, 1'b0);
  endtask

  task automatic queue_point(data_t px, data_t py, data_t pz, logic last, bit wait_drain);
    queue_word(REQ_XFORM, 4'($urandom_range(0, 15)), data_t'($urandom), px, py, pz, last,
               0, wait_drain);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit          burst;
    req_t        kind;
    int unsigned gap;

    clk            = 1'b0;
    rst_n          = 1'b0;
    word_on_bus    = 1'b0;
    send_gap_left  = 0;
    recv_hold_left = 0;
    mismatch_count = 0;
    results_seen   = 0;
    cycle_count    = 0;
    foreach (coef_mirror[i]) coef_mirror[i] = '0;

    in_bus.valid      = 1'b0;
    in_bus.req_type   = REQ_LOAD;
    in_bus.coef_index = '0;
    in_bus.coef_value = '0;
    in_bus.point_x    = '0;
    in_bus.point_y    = '0;
    in_bus.point_z    = '0;
    in_bus.last_in    = 1'b0;
    out_bus.ready     = 1'b0;

    // Directed part. A point before any load sees the cleared matrix.
    queue_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF, 1'b1, 1'b0);
    // Coefficients on the diagonal, in the translation row and in the w column, most at the range limits.
    queue_load(4'd0,  32'sh7FFF_FFFF);
    queue_load(4'd5,  32'sh8000_0000);
    queue_load(4'd10, 32'sh0001_0000);
    queue_load(4'd15, 32'sh7FFF_FFFF);
    queue_load(4'd12, 32'sh8000_0000);
    queue_load(4'd3,  32'sh0000_0001);
    // Saturation high and low on different columns.
    queue_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0);
    queue_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 1'b0);
    // Small negative products must round toward minus infinity.
    queue_point(32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0001_0000, 1'b0, 1'b0);
    queue_load(4'd1, 32'shFFFF_FFFF);
    queue_load(4'd6, 32'sh0001_8000);
    queue_point(32'sh0003_0000, 32'shFFFF_8000, 32'sh8000_0000, 1'b1, 1'b0);
    // The origin gives the translation row alone.
    queue_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0, 1'b0);
    queue_load(4'd13, 32'sh7FFF_0000);
    queue_load(4'd14, 32'sh0000_FFFF);
    // Loads right behind points, then a point issued only once all is drained.
    queue_point(32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh0000_0000, 1'b1, 1'b1);
    queue_point(32'shFFFF_0000, 32'sh0002_0000, 32'shFFFF_FFFF, 1'b0, 1'b0);

    // Random part: about one word in five is a load, the rest are points.
    // Every third stretch of 150 words is sent back to back, and every 300th
    // word waits for the pipeline to drain completely.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      burst = ((i / 150) % 3) == 1;
      gap   = burst ? 0 : $urandom_range(0, 10);
      kind  = ($urandom_range(0, 4) == 0) ? REQ_LOAD : REQ_XFORM;
      queue_word(kind, 4'($urandom_range(0, 15)), pick_fixed(), pick_fixed(), pick_fixed(),
                 pick_fixed(), 1'($urandom_range(0, 1)), gap, (i % 300) == 299);
    end

    // Reset is held, then released at a falling edge away from the sampling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait until every word is taken and every result is back, then let the
    // pipeline settle so that a stray extra word would still be caught.
    while (pending_words_q.size() != 0 || due_points_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && due_points_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
